[rtl/fpwg_pkg.sv]
// Shared types, codes and constants of the interlaced multicolour pixel write generator.
// Used by the front end, the descriptor queue, the write sequencer and the top level.
// Depends on nothing.
package fpwg_pkg;

  // Request command codes
  localparam logic [2:0] CMD_BITMAP      = 3'd0;
  localparam logic [2:0] CMD_PIXEL       = 3'd1;
  localparam logic [2:0] CMD_BLOCK_BMP   = 3'd2;
  localparam logic [2:0] CMD_BLOCK_ATTR  = 3'd3;
  localparam logic [2:0] CMD_PAR_ATTR    = 3'd4;
  localparam logic [2:0] CMD_PAR_BMP     = 3'd5;

  // Colour slot codes
  localparam logic [1:0] SLOT_MC1 = 2'd0;
  localparam logic [1:0] SLOT_BG  = 2'd1;
  localparam logic [1:0] SLOT_FG  = 2'd2;
  localparam logic [1:0] SLOT_MC2 = 2'd3;

  // Address map constants
  localparam logic [15:0] BITMAP_BASE_LO = 16'h4000;
  localparam logic [15:0] BITMAP_BASE_HI = 16'h6000;
  localparam logic [15:0] LINE_STRIDE    = 16'd312;
  localparam logic [15:0] REG_BASE       = 16'h1066;
  localparam logic [15:0] REG_BASE_MID   = 16'h1062;
  localparam logic [15:0] REG_STRIDE     = 16'd17;
  localparam logic [15:0] COLOUR_OFFSET  = 16'h0400;
  localparam logic [15:0] ROW_STRIDE     = 16'd40;

  localparam logic [15:0] LUM_BASE_A [4] = '{16'h2800, 16'h3000, 16'h3800, 16'h9000};
  localparam logic [15:0] LUM_BASE_B [4] = '{16'h9800, 16'h7000, 16'h8000, 16'h8800};

  // Shape of a request as seen by the sequencer
  typedef enum logic [1:0] {
    KIND_BITMAP     = 2'd0,
    KIND_PIXEL      = 2'd1,
    KIND_BLOCK_BMP  = 2'd2,
    KIND_BLOCK_ATTR = 2'd3
  } kind_t;

  // Kind of one write
  typedef enum logic [1:0] {
    OP_BITMAP = 2'd0,
    OP_FULL   = 2'd1,
    OP_HUE    = 2'd2,
    OP_LUM    = 2'd3
  } op_t;

  typedef struct packed {
    kind_t       kind;
    logic        wide;    // slot split over hue and luminance bytes
    logic [8:0]  bx;
    logic [8:0]  by;
    logic [7:0]  colour;
    logic [1:0]  slot;
  } desc_t;

  typedef struct packed {
    op_t  op;
    logic dx;
    logic dy;
    logic last;
  } step_t;

  // Write number step of a request of the given shape.
  function automatic step_t step_decode(kind_t kind, logic wide, logic [2:0] step);
    step_t      st;
    logic [1:0] sub;
    st  = '{op: OP_BITMAP, dx: 1'b0, dy: 1'b0, last: 1'b0};
    sub = 2'd0;
    unique case (kind)
      KIND_BITMAP: begin
        st.last = 1'b1;
      end
      KIND_PIXEL: begin
        if (step == 3'd1) begin
          st.op   = wide ? OP_HUE : OP_FULL;
          st.last = !wide;
        end else if (step != 3'd0) begin
          st.op   = OP_LUM;
          st.last = 1'b1;
        end
      end
      KIND_BLOCK_BMP: begin
        st.dx   = step[0];
        st.dy   = step[1];
        st.last = (step[1:0] == 2'd3);
      end
      KIND_BLOCK_ATTR: begin
        if (wide) begin
          // Four writes per line: bitmap, hue, luminance, right-hand bitmap.
          st.dy   = step[2];
          st.last = (step == 3'd7);
          case (step[1:0])
            2'd0:    st.op = OP_BITMAP;
            2'd1:    st.op = OP_HUE;
            2'd2:    st.op = OP_LUM;
            default: st.dx = 1'b1;
          endcase
        end else begin
          // Three writes per line: bitmap, colour register, right-hand bitmap.
          st.dy   = (step >= 3'd3);
          sub     = st.dy ? 2'(step - 3'd3) : step[1:0];
          st.last = (step == 3'd5);
          case (sub)
            2'd0:    st.op = OP_BITMAP;
            2'd1:    st.op = OP_FULL;
            default: st.dx = 1'b1;
          endcase
        end
      end
      default: st.last = 1'b1;
    endcase
    return st;
  endfunction

endpackage

[rtl/fpwg_if.sv]
// Valid/ready channel interfaces for plot requests and masked byte writes.
// Depends on nothing; the payload widths are those of the request and write fields.
interface fpwg_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] colour;
  logic [1:0] slot;

  modport source (output valid, cmd, pos_x, pos_y, colour, slot, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, colour, slot, output ready);
endinterface

interface fpwg_wr_if;
  logic        valid;
  logic        ready;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [7:0]  write_mask;
  logic        last_write;

  modport source (output valid, write_address, write_data, write_mask, last_write,
                  input ready);
  modport sink   (input valid, write_address, write_data, write_mask, last_write,
                  output ready);
endinterface

[rtl/fpwg_front.sv]
// Request front end: accepts plot requests and turns them into sequencer descriptors.
// Depends on fpwg_pkg and fpwg_req_if.
module fpwg_front (
  fpwg_req_if.sink        req,
  output logic            push,
  output fpwg_pkg::desc_t push_desc,
  input  logic            push_ready
);

  logic       known;
  logic [1:0] par_slot;
  logic       block;

  // The parity forms take foreground on even columns and background on odd ones.
  assign par_slot = req.pos_x[0] ? fpwg_pkg::SLOT_BG : fpwg_pkg::SLOT_FG;

  always_comb begin
    known          = 1'b1;
    push_desc.kind = fpwg_pkg::KIND_BITMAP;
    push_desc.slot = req.slot;
    unique case (req.cmd)
      fpwg_pkg::CMD_BITMAP:     push_desc.kind = fpwg_pkg::KIND_BITMAP;
      fpwg_pkg::CMD_PIXEL:      push_desc.kind = fpwg_pkg::KIND_PIXEL;
      fpwg_pkg::CMD_BLOCK_BMP:  push_desc.kind = fpwg_pkg::KIND_BLOCK_BMP;
      fpwg_pkg::CMD_BLOCK_ATTR: push_desc.kind = fpwg_pkg::KIND_BLOCK_ATTR;
      fpwg_pkg::CMD_PAR_ATTR: begin
        push_desc.kind = fpwg_pkg::KIND_BLOCK_ATTR;
        push_desc.slot = par_slot;
      end
      fpwg_pkg::CMD_PAR_BMP: begin
        push_desc.kind = fpwg_pkg::KIND_BLOCK_BMP;
        push_desc.slot = par_slot;
      end
      default: known = 1'b0;
    endcase

    block = (push_desc.kind == fpwg_pkg::KIND_BLOCK_BMP) ||
            (push_desc.kind == fpwg_pkg::KIND_BLOCK_ATTR);

    push_desc.wide   = (push_desc.slot == fpwg_pkg::SLOT_BG) ||
                       (push_desc.slot == fpwg_pkg::SLOT_FG);
    push_desc.bx     = block ? {req.pos_x, 1'b0} : {1'b0, req.pos_x};
    push_desc.by     = block ? {req.pos_y, 1'b0} : {1'b0, req.pos_y};
    push_desc.colour = req.colour;
  end

  // Unused commands are taken and dropped without reaching the queue.
  assign req.ready = push_ready;
  assign push      = req.valid && push_ready && known;

endmodule

[rtl/fpwg_queue.sv]
// Two-entry descriptor queue between the front end and the write sequencer.
// Depends on fpwg_pkg.
module fpwg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpwg_pkg::desc_t push_desc,
  output logic            push_ready,
  output logic            head_valid,
  output fpwg_pkg::desc_t head,
  input  logic            pop
);

  fpwg_pkg::desc_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/fpwg_back.sv]
// Write sequencer: steps through the writes of the head descriptor, one per cycle while
// the receiver is ready, and computes each address, data and mask into the output register.
// Depends on fpwg_pkg and fpwg_wr_if.
module fpwg_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  fpwg_pkg::desc_t head,
  output logic            pop,
  fpwg_wr_if.source       wr
);

  logic [2:0]      step;
  fpwg_pkg::step_t st;
  logic            load;

  logic [8:0]  px;
  logic [8:0]  py;
  logic [5:0]  row;
  logic        lower_band;
  logic        z;
  logic [15:0] bm_addr;
  logic [15:0] p;
  logic [15:0] full_addr;
  logic [15:0] q;
  logic [15:0] lum_base;
  logic [15:0] next_addr;
  logic [7:0]  next_data;
  logic [7:0]  next_mask;

  logic        wr_valid;
  logic [15:0] wr_addr;
  logic [7:0]  wr_data;
  logic [7:0]  wr_mask;
  logic        wr_last;

  assign st   = fpwg_pkg::step_decode(head.kind, head.wide, step);
  assign load = head_valid && (!wr_valid || wr.ready);
  assign pop  = load && st.last;

  assign px  = head.bx | {8'd0, st.dx};
  assign py  = head.by | {8'd0, st.dy};
  assign row = py[8:3];

  // Lines 192 to 207 sit in a second bank, the last eight only left of column 96.
  assign lower_band = (py >= 9'd192) && ((py < 9'd200) || ((py < 9'd208) && (px < 9'd96)));

  // The column byte offset only takes the low eight bits of the column.
  assign bm_addr = (lower_band ? fpwg_pkg::BITMAP_BASE_HI : fpwg_pkg::BITMAP_BASE_LO)
                   + 16'(row) * fpwg_pkg::LINE_STRIDE
                   + {7'd0, px[7:2], 3'b000} + {7'd0, py};

  assign z = (head.slot == fpwg_pkg::SLOT_MC2);
  assign p = fpwg_pkg::REG_BASE + 16'(py) * fpwg_pkg::REG_STRIDE + (z ? 16'd5 : 16'd0);

  always_comb begin
    if (!py[0]) begin
      if (py < 9'd192) begin
        full_addr = p;
      end else if (py == 9'd192) begin
        full_addr = fpwg_pkg::REG_BASE_MID + (z ? 16'd2 : 16'd0);
      end else begin
        full_addr = p + 16'd2;
      end
    end else begin
      full_addr = (py < 9'd193) ? p - 16'd3 : p - 16'd1;
    end
  end

  assign q = 16'(row) * fpwg_pkg::ROW_STRIDE + {9'd0, px[8:2]};

  always_comb begin
    if (py < 9'd192) begin
      lum_base = fpwg_pkg::LUM_BASE_A[py[2:1]];
    end else if (lower_band) begin
      lum_base = fpwg_pkg::LUM_BASE_B[py[2:1]];
    end else begin
      lum_base = fpwg_pkg::LUM_BASE_B[py[2:1]] - fpwg_pkg::COLOUR_OFFSET;
    end
  end

  always_comb begin
    next_addr = bm_addr;
    next_data = 8'd0;
    next_mask = 8'd0;
    case (st.op)
      fpwg_pkg::OP_BITMAP: begin
        next_mask = 8'h03 << {~px[1:0], 1'b0};
        next_data = {6'd0, head.slot} << {~px[1:0], 1'b0};
      end
      fpwg_pkg::OP_FULL: begin
        next_addr = full_addr;
        next_data = head.colour;
        next_mask = 8'hFF;
      end
      fpwg_pkg::OP_HUE: begin
        next_addr = lum_base + q + fpwg_pkg::COLOUR_OFFSET;
        if (head.slot == fpwg_pkg::SLOT_FG) begin
          next_data = {4'd0, head.colour[3:0]};
          next_mask = 8'h0F;
        end else begin
          next_data = {head.colour[3:0], 4'd0};
          next_mask = 8'hF0;
        end
      end
      default: begin
        next_addr = lum_base + q;
        if (head.slot == fpwg_pkg::SLOT_FG) begin
          next_data = {head.colour[7:4], 4'd0};
          next_mask = 8'hF0;
        end else begin
          next_data = {4'd0, head.colour[7:4]};
          next_mask = 8'h0F;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= 3'd0;
      wr_valid <= 1'b0;
    end else begin
      if (load) begin
        step     <= st.last ? 3'd0 : step + 3'd1;
        wr_valid <= 1'b1;
      end else if (wr.ready) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr_addr <= next_addr;
      wr_data <= next_data;
      wr_mask <= next_mask;
      wr_last <= st.last;
    end
  end

  assign wr.valid         = wr_valid;
  assign wr.write_address = wr_addr;
  assign wr.write_data    = wr_data;
  assign wr.write_mask    = wr_mask;
  assign wr.last_write    = wr_last;

  // A request part-way through its writes must still be at the head of the queue.
  a_step_has_head: assert property (@(posedge clk) disable iff (rst)
    (step != 3'd0) |-> head_valid)
    else $error("write sequence in progress without a queued request");

  a_data_in_mask: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> ((wr_data & ~wr_mask) == 8'h00))
    else $error("write data outside its mask");

  a_mask_set: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> (wr_mask != 8'h00))
    else $error("write with an empty mask");

  a_pop_flags_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (wr_valid && wr_last))
    else $error("request retired without a flagged final write");

endmodule

[rtl/fli_pixel_write_generator.sv]
// Top level of the interlaced multicolour pixel write generator.
// Depends on fpwg_pkg, fpwg_if, fpwg_front, fpwg_queue and fpwg_back.
//
// Usage: plot requests arrive on the req channel, one beat per request, and the
// masked byte writes leave on the wr channel, one beat per write, in order, with
// last_write set on the final beat of each request. Writes go to a 64 KiB image
// kept elsewhere; the block keeps no image state.
// A request yields 1 write (bitmap pixel), 2 or 3 (pixel with attributes),
// 4 (2x2 bitmap forms), 6 or 8 (2x2 attribute forms). Unused commands are taken
// and yield nothing.
// The first write of a request passes through the descriptor queue and then the
// output register before it is presented on wr. The output register issues one
// write per cycle while the receiver holds ready high; the sequencer step counter
// moving through the writes of a request sets the rate.
// A two-entry descriptor queue sits between the front end and the sequencer, so
// requests keep being taken while writes are still leaving.
// When the receiver holds ready low, the current write stays on wr, the sequencer
// stops, and req stops once the queue is full. Reset (rst, synchronous) empties the
// queue and drops any write in flight.
module fli_pixel_write_generator (
  input  logic      clk,
  input  logic      rst,
  fpwg_req_if.sink  req,
  fpwg_wr_if.source wr
);

  logic            push;
  logic            push_ready;
  fpwg_pkg::desc_t push_desc;
  logic            head_valid;
  fpwg_pkg::desc_t head;
  logic            pop;

  fpwg_front u_front (
    .req        (req),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready)
  );

  fpwg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  fpwg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .wr         (wr)
  );

endmodule
